// ===== rtl/core/bced_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bced_pkg
// Shared types and constants for the button click event detector.
// ----------------------------------------------------------------------------
package bced_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned MsW    = 16;
  localparam int unsigned StateW = 3;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned CfgIdxW = 4;

  // Reported button states.
  localparam logic [StateW-1:0] ST_RELEASED  = 3'd0;
  localparam logic [StateW-1:0] ST_PRESSED   = 3'd1;
  localparam logic [StateW-1:0] ST_UP        = 3'd2;
  localparam logic [StateW-1:0] ST_DOWN      = 3'd3;
  localparam logic [StateW-1:0] ST_DBLCLICK  = 3'd4;
  localparam logic [StateW-1:0] ST_ONECLICK  = 3'd5;
  localparam logic [StateW-1:0] ST_LONGCLICK = 3'd6;

  // Long click modes.
  localparam logic [ModeW-1:0] MODE_ONCE      = 2'd0;
  localparam logic [ModeW-1:0] MODE_CONTINUED = 2'd1;
  localparam logic [ModeW-1:0] MODE_SERIES    = 2'd2;
  localparam logic [ModeW-1:0] MODE_ALT_CONT  = 2'd3;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] REG_ACTIVE_LOW  = 4'd0;
  localparam logic [CfgIdxW-1:0] REG_NORM_CLOSED = 4'd1;
  localparam logic [CfgIdxW-1:0] REG_DEBOUNCE    = 4'd2;
  localparam logic [CfgIdxW-1:0] REG_DOUBLE      = 4'd3;
  localparam logic [CfgIdxW-1:0] REG_LONG        = 4'd4;
  localparam logic [CfgIdxW-1:0] REG_MODE        = 4'd5;
  localparam logic [CfgIdxW-1:0] REG_SERIES      = 4'd6;
  localparam logic [CfgIdxW-1:0] REG_VIRTUAL     = 4'd7;

  // Register reset values.
  localparam logic [MsW-1:0] DEBOUNCE_RST = 16'd50;
  localparam logic [MsW-1:0] DOUBLE_RST   = 16'd300;
  localparam logic [MsW-1:0] LONG_RST     = 16'd1000;
  localparam logic [MsW-1:0] SERIES_RST   = 16'd100;
  localparam logic [MsW-1:0] SERIES_DFLT  = 16'd100;

  typedef struct packed {
    logic             active_low;
    logic             norm_closed;
    logic [MsW-1:0]   debounce_ms;
    logic [MsW-1:0]   double_ms;
    logic [MsW-1:0]   long_ms;
    logic [ModeW-1:0] mode;
    logic [MsW-1:0]   series_ms;
    logic             virtual_en;
  } cfg_t;

  typedef struct packed {
    logic             req_type;
    logic             pin_level;
    logic [TimeW-1:0] now_ms;
  } item_t;

endpackage

// ===== rtl/core/bced_cfg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bced_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module bced_cfg import bced_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MsW-1:0]     cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ACTIVE_LOW:  cfg_d.active_low  = cfg_wdata_i[0];
        REG_NORM_CLOSED: cfg_d.norm_closed = cfg_wdata_i[0];
        REG_DEBOUNCE:    cfg_d.debounce_ms = cfg_wdata_i;
        REG_DOUBLE:      cfg_d.double_ms   = cfg_wdata_i;
        REG_LONG:        cfg_d.long_ms     = cfg_wdata_i;
        REG_MODE:        cfg_d.mode        = cfg_wdata_i[ModeW-1:0];
        REG_SERIES:      cfg_d.series_ms   = cfg_wdata_i;
        REG_VIRTUAL:     cfg_d.virtual_en  = cfg_wdata_i[0];
        default:         cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_low  <= 1'b1;
      cfg_q.norm_closed <= 1'b0;
      cfg_q.debounce_ms <= DEBOUNCE_RST;
      cfg_q.double_ms   <= DOUBLE_RST;
      cfg_q.long_ms     <= LONG_RST;
      cfg_q.mode        <= MODE_ONCE;
      cfg_q.series_ms   <= SERIES_RST;
      cfg_q.virtual_en  <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/core/bced_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bced_core
// Debounce and click state logic: computes the next state and the reported
// button state for one item and updates the state when the item advances.
// ----------------------------------------------------------------------------
module bced_core import bced_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cfg_t              cfg_i,
  input  item_t             item_i,
  input  logic              advance_i,
  output logic [StateW-1:0] state_o
);

  logic [StateW-1:0] last_q, last_d;
  logic              closed_q, closed_d;
  logic              deb_act_q, deb_act_d;
  logic              one_q, one_d;
  logic              long_q, long_d;
  logic [TimeW-1:0]  ev_q, ev_d;
  logic [TimeW-1:0]  dbl_q, dbl_d;

  logic [TimeW-1:0]  since_event;
  logic [TimeW-1:0]  since_dbl;
  logic [TimeW-1:0]  deb_w, dbl_w, long_w, iv_w;
  logic [ModeW-1:0]  eff_mode;
  logic              closed_now;
  logic              debounce_on;
  logic              hold;
  logic              settle;

  assign since_event = item_i.now_ms - ev_q;
  assign since_dbl   = item_i.now_ms - dbl_q;
  assign deb_w  = {{(TimeW-MsW){1'b0}}, cfg_i.debounce_ms};
  assign dbl_w  = {{(TimeW-MsW){1'b0}}, cfg_i.double_ms};
  assign long_w = {{(TimeW-MsW){1'b0}}, cfg_i.long_ms};
  assign iv_w   = {{(TimeW-MsW){1'b0}},
                   (cfg_i.series_ms == '0) ? SERIES_DFLT : cfg_i.series_ms};
  assign eff_mode    = (cfg_i.mode == MODE_ALT_CONT) ? MODE_CONTINUED : cfg_i.mode;
  assign closed_now  = item_i.pin_level ^ cfg_i.active_low ^ cfg_i.norm_closed;
  assign debounce_on = (cfg_i.debounce_ms != '0);
  // While a debounce interval runs, polls change nothing.
  assign hold = debounce_on && deb_act_q && (since_event < deb_w);

  always_comb begin
    last_d    = last_q;
    closed_d  = closed_q;
    deb_act_d = deb_act_q;
    one_d     = one_q;
    long_d    = long_q;
    ev_d      = ev_q;
    dbl_d     = dbl_q;
    settle    = 1'b0;

    if (item_i.req_type) begin
      one_d  = 1'b0;
      long_d = 1'b0;
      last_d = closed_q ? ST_PRESSED : ST_RELEASED;
    end else if (!hold) begin
      if (closed_now == closed_q) begin
        if (!deb_act_q) begin
          if (!closed_now) begin
            last_d = ST_RELEASED;
            if (since_dbl > dbl_w) begin
              if (cfg_i.virtual_en && one_q) begin
                last_d = ST_ONECLICK;
              end
              one_d  = 1'b0;
              long_d = 1'b0;
            end
          end else if ((since_event < long_w) && !long_q) begin
            last_d = ST_PRESSED;
          end else begin
            if (!long_q) begin
              if (eff_mode == MODE_SERIES) begin
                ev_d = item_i.now_ms;
              end
              long_d = 1'b1;
              last_d = ST_LONGCLICK;
            end else if (eff_mode == MODE_ONCE) begin
              last_d = ST_PRESSED;
            end else if (eff_mode == MODE_SERIES) begin
              if (since_event >= iv_w) begin
                ev_d   = item_i.now_ms;
                last_d = ST_LONGCLICK;
              end else begin
                last_d = ST_PRESSED;
              end
            end else begin
              last_d = ST_LONGCLICK;
            end
            one_d = 1'b0;
          end
        end
      end else if (debounce_on) begin
        if (!deb_act_q) begin
          ev_d      = item_i.now_ms;
          deb_act_d = 1'b1;
          // A continued long click keeps reporting through the bounce.
          if (!((last_q == ST_LONGCLICK) && (eff_mode == MODE_CONTINUED))) begin
            last_d = closed_q ? ST_PRESSED : ST_RELEASED;
          end
        end else if (since_event >= deb_w) begin
          settle = 1'b1;
        end
      end else begin
        settle = 1'b1;
      end

      if (settle) begin
        ev_d      = item_i.now_ms;
        deb_act_d = 1'b0;
        closed_d  = closed_now;
        if (closed_now) begin
          if (!one_q) begin
            last_d = ST_DOWN;
            one_d  = 1'b1;
            dbl_d  = item_i.now_ms;
          end else if (since_dbl <= dbl_w) begin
            last_d = ST_DBLCLICK;
            one_d  = 1'b0;
          end
        end else begin
          last_d = ST_UP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q    <= ST_RELEASED;
      closed_q  <= 1'b0;
      deb_act_q <= 1'b0;
      one_q     <= 1'b0;
      long_q    <= 1'b0;
      ev_q      <= '0;
      dbl_q     <= '0;
    end else if (advance_i) begin
      last_q    <= last_d;
      closed_q  <= closed_d;
      deb_act_q <= deb_act_d;
      one_q     <= one_d;
      long_q    <= long_d;
      ev_q      <= ev_d;
      dbl_q     <= dbl_d;
    end
  end

  assign state_o = last_d;

endmodule

// ===== rtl/core/button_click_event_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_click_event_detector
// Button debounce with click, double click and long click detection.
// ----------------------------------------------------------------------------
// Each item is either a poll (pin level plus a wrapping millisecond timestamp)
// or a request to clear the click state, and each item yields exactly one
// button state. The block takes one item per clock when not stalled: an item sits
// in the input register, the state logic evaluates it in a single pass against
// the current state, and the result is registered in the output register when
// the item advances. The input side accepts whenever the input register is
// empty, or when its item moves on to the output register in the same cycle,
// which happens when the output register is free or being emptied. A waiting
// result that is not taken therefore stalls the input after one more item.
// The user must write configuration through the register port only while no
// item is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module button_click_event_detector import bced_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [MsW-1:0]     cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               in_req_type_i,
  input  logic               in_pin_level_i,
  input  logic [TimeW-1:0]   in_now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [StateW-1:0]  out_button_state_o
);

  cfg_t              cfg;
  item_t             item_q;
  logic              in_vld_q;
  logic              out_vld_q;
  logic [StateW-1:0] res_q;
  logic [StateW-1:0] res_d;
  logic              advance;
  logic              in_fire;

  bced_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bced_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .item_i    (item_q),
    .advance_i (advance),
    .state_o   (res_d)
  );

  // An item moves from the input register to the result register whenever
  // the result register is empty or is being read out.
  assign advance    = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || advance;
  assign in_fire    = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_fire) begin
        in_vld_q <= 1'b1;
      end else if (advance) begin
        in_vld_q <= 1'b0;
      end
      if (advance) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.req_type  <= in_req_type_i;
      item_q.pin_level <= in_pin_level_i;
      item_q.now_ms    <= in_now_ms_i;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign out_button_state_o = res_q;

  a_advance_fills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_vld_q)
    else $error("advanced item did not reach the result register");

  a_stalled_item_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_vld_q && !advance) |=> (in_vld_q && $stable(item_q)))
    else $error("stalled item lost or changed in the input register");

  a_empty_accepts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_vld_q |-> in_ready_o)
    else $error("empty input register refused an item");

  a_result_in_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (res_q != 3'd7))
    else $error("result holds an unused state code");

  a_result_stable : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> (out_vld_q && $stable(res_q)))
    else $error("waiting result changed before it was taken");

endmodule
